// ----- sv/alias_table_sampler_defines.svh -----
// assertion macros for the alias table sampler
`ifndef ALIAS_TABLE_SAMPLER_DEFINES_SVH
`define ALIAS_TABLE_SAMPLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ats_pkg.sv -----
`timescale 1ns / 1ps
package ats_pkg;

    localparam int ENTRY_BITS = 8;
    localparam int CNT_BITS   = ENTRY_BITS + 1;
    localparam int FRAC_BITS  = 16;
    localparam int PROB_BITS  = FRAC_BITS + 1;
    localparam int THR_BITS   = FRAC_BITS + 9;
    localparam int PROD_BITS  = THR_BITS + CNT_BITS;

    localparam logic [THR_BITS-1:0] ONE_FIX = THR_BITS'(1) << FRAC_BITS;
    localparam logic [THR_BITS-1:0] THR_MAX = {THR_BITS{1'b1}};

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic KIND_BUILD  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic load;
        logic build_init;
        logic emit_ovf;
        logic emit_not_built;
        logic emit_range;
        logic smp_read;
        logic emit_sample;
        logic sc_read;
        logic sc_mul;
        logic sc_write;
        logic pr_qread;
        logic pr_tread;
        logic pr_calc;
        logic pr_write;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic ovf;
        logic ready;
        logic range_err;
        logic scale_last;
        logic pair_done;
    } t_stat;

endpackage

// ----- sv/alias_table_sampler.sv -----
// a sample's word follows its table read and S_SMP; error words come the next cycle
// build: read, scale, write each loaded entry; pair until a queue empties; then finish
// a new sample is taken only when busy is low again, after its registered table read
// busy is high while a build or a table read is in flight; o_result_valid pulses once
// results cannot be stalled by the receiver
// reset (synchronous, active low) clears the table-ready flag, alias links and counters
`timescale 1ns / 1ps
`include "alias_table_sampler_defines.svh"
module alias_table_sampler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ats_pkg::ENTRY_BITS-1:0] i_cfg_wr_data,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [ats_pkg::PROB_BITS-1:0]  i_probability,
    input  logic                           i_last_probability,
    input  logic [ats_pkg::ENTRY_BITS-1:0] i_rand_index,
    input  logic [ats_pkg::FRAC_BITS-1:0]  i_rand_fraction,
    output logic                           o_result_valid,
    output logic                           o_result_kind,
    output logic [ats_pkg::ENTRY_BITS-1:0] o_outcome,
    output logic                           o_took_alias,
    output logic [1:0]                     o_status
);

    ats_pkg::t_cmd  cmd;
    ats_pkg::t_stat stat;

    ats_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_command          (i_command),
        .i_last_probability (i_last_probability),
        .i_stat             (stat),
        .o_cmd              (cmd),
        .busy               (busy)
    );

    ats_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_probability   (i_probability),
        .i_rand_index    (i_rand_index),
        .i_rand_fraction (i_rand_fraction),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_outcome       (o_outcome),
        .o_took_alias    (o_took_alias),
        .o_status        (o_status)
    );

    `ATS_ASSERT_NEXT(a_last_load_builds, start && !busy && (i_command == ats_pkg::CMD_LOAD) && i_last_probability, busy, "last load did not start a build")
    `ATS_ASSERT_NOW(a_error_outcome_zero, o_result_valid && (o_status != ats_pkg::ST_OK), (o_outcome == '0) && !o_took_alias, "error word carries an outcome")
    `ATS_ASSERT_NOW(a_alias_only_sample, o_took_alias, o_result_valid && (o_result_kind == ats_pkg::KIND_SAMPLE) && (o_status == ats_pkg::ST_OK), "alias flag outside a good sample")

endmodule

// ----- sv/ats_ctrl.sv -----
`timescale 1ns / 1ps
module ats_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_command,
    input  logic           i_last_probability,
    input  ats_pkg::t_stat i_stat,
    output ats_pkg::t_cmd  o_cmd,
    output logic           busy
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SC_RD  = 10'b00_0000_0010,
        S_SC_MUL = 10'b00_0000_0100,
        S_SC_WR  = 10'b00_0000_1000,
        S_PR_QRD = 10'b00_0001_0000,
        S_PR_TRD = 10'b00_0010_0000,
        S_PR_CLC = 10'b00_0100_0000,
        S_PR_WR  = 10'b00_1000_0000,
        S_FINISH = 10'b01_0000_0000,
        S_SMP    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_command == ats_pkg::CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_last_probability) begin
                            o_cmd.build_init = 1'b1;
                            n_state = S_SC_RD;
                        end else if (i_stat.ovf) begin
                            o_cmd.emit_ovf = 1'b1;
                        end
                    end else if (!i_stat.ready) begin
                        o_cmd.emit_not_built = 1'b1;
                    end else if (i_stat.range_err) begin
                        o_cmd.emit_range = 1'b1;
                    end else begin
                        o_cmd.smp_read = 1'b1;
                        n_state = S_SMP;
                    end
                end
            end
            S_SC_RD: begin
                o_cmd.sc_read = 1'b1;
                n_state = S_SC_MUL;
            end
            S_SC_MUL: begin
                o_cmd.sc_mul = 1'b1;
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                o_cmd.sc_write = 1'b1;
                n_state = i_stat.scale_last ? S_PR_QRD : S_SC_RD;
            end
            S_PR_QRD: begin
                if (i_stat.pair_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.pr_qread = 1'b1;
                    n_state = S_PR_TRD;
                end
            end
            S_PR_TRD: begin
                o_cmd.pr_tread = 1'b1;
                n_state = S_PR_CLC;
            end
            S_PR_CLC: begin
                o_cmd.pr_calc = 1'b1;
                n_state = S_PR_WR;
            end
            S_PR_WR: begin
                o_cmd.pr_write = 1'b1;
                n_state = S_PR_QRD;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            S_SMP: begin
                o_cmd.emit_sample = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- sv/ats_datapath.sv -----
`timescale 1ns / 1ps
module ats_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ats_pkg::ENTRY_BITS-1:0]      i_cfg_wr_data,
    input  logic [ats_pkg::PROB_BITS-1:0]       i_probability,
    input  logic [ats_pkg::ENTRY_BITS-1:0]      i_rand_index,
    input  logic [ats_pkg::FRAC_BITS-1:0]       i_rand_fraction,
    input  ats_pkg::t_cmd                       i_cmd,
    output ats_pkg::t_stat                      o_stat,
    output logic                                o_result_valid,
    output logic                                o_result_kind,
    output logic [ats_pkg::ENTRY_BITS-1:0]      o_outcome,
    output logic                                o_took_alias,
    output logic [1:0]                          o_status
);

    localparam int DEPTH = 1 << ats_pkg::ENTRY_BITS;

    logic [ats_pkg::THR_BITS-1:0]   thr_mem   [DEPTH];
    logic [ats_pkg::ENTRY_BITS-1:0] alias_mem [DEPTH];
    logic [ats_pkg::ENTRY_BITS-1:0] sq_mem    [DEPTH];
    logic [ats_pkg::ENTRY_BITS-1:0] lq_mem    [DEPTH];

    logic [DEPTH-1:0]                r_valid;
    logic [ats_pkg::ENTRY_BITS-1:0]  r_hi;
    logic [ats_pkg::CNT_BITS-1:0]    r_cnt, r_sz, r_sn, r_ln;
    logic [ats_pkg::ENTRY_BITS-1:0]  r_i, r_sh, r_lh, r_s, r_l, r_sq_q, r_lq_q;
    logic [ats_pkg::ENTRY_BITS-1:0]  r_ridx, r_alias_q;
    logic [ats_pkg::FRAC_BITS-1:0]   r_frac;
    logic                            r_vld, r_ready, r_ovf;
    logic [ats_pkg::THR_BITS-1:0]    r_thr_a, r_thr_b, r_tl;
    logic [ats_pkg::PROD_BITS-1:0]   r_prod;

    logic                            r_out_valid, r_kind, r_took;
    logic [ats_pkg::ENTRY_BITS-1:0]  r_outcome;
    logic [1:0]                      r_status;

    logic                            n_kind, n_took;
    logic [ats_pkg::ENTRY_BITS-1:0]  n_outcome;
    logic [1:0]                      n_status;

    logic [ats_pkg::CNT_BITS-1:0]    cap;
    logic                            ovf;
    logic [ats_pkg::THR_BITS-1:0]    sat, gap, push_thr;
    logic                            thr_we, push, push_small, took;
    logic [ats_pkg::ENTRY_BITS-1:0]  thr_waddr, push_data, rd_a_addr;
    logic [ats_pkg::THR_BITS-1:0]    thr_wdata;

    assign cap = {1'b0, r_hi} + ats_pkg::CNT_BITS'(1);
    assign ovf = (r_cnt >= cap);
    assign sat = (|r_prod[ats_pkg::PROD_BITS-1:ats_pkg::THR_BITS]) ? ats_pkg::THR_MAX
               : r_prod[ats_pkg::THR_BITS-1:0];
    assign gap = ats_pkg::ONE_FIX - r_thr_a;

    always_comb begin
        thr_we    = 1'b0;
        thr_waddr = r_l;
        thr_wdata = r_tl;
        if (i_cmd.load && !ovf) begin
            thr_we    = 1'b1;
            thr_waddr = r_cnt[ats_pkg::ENTRY_BITS-1:0];
            thr_wdata = ats_pkg::THR_BITS'(i_probability);
        end else if (i_cmd.sc_write) begin
            thr_we    = 1'b1;
            thr_waddr = r_i;
            thr_wdata = sat;
        end else if (i_cmd.pr_write) begin
            thr_we = 1'b1;
        end
    end

    always_comb begin
        push       = i_cmd.sc_write | i_cmd.pr_write;
        push_thr   = i_cmd.sc_write ? sat : r_tl;
        push_data  = i_cmd.sc_write ? r_i : r_l;
        push_small = (push_thr < ats_pkg::ONE_FIX);
    end

    always_comb begin
        rd_a_addr = r_i;
        if (i_cmd.pr_tread) begin
            rd_a_addr = r_sq_q;
        end else if (i_cmd.smp_read) begin
            rd_a_addr = i_rand_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (thr_we) begin
            thr_mem[thr_waddr] <= thr_wdata;
        end
        if (i_cmd.sc_read || i_cmd.pr_tread || i_cmd.smp_read) begin
            r_thr_a <= thr_mem[rd_a_addr];
        end
        if (i_cmd.pr_tread) begin
            r_thr_b <= thr_mem[r_lq_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pr_write) begin
            alias_mem[r_s] <= r_l;
        end
        if (i_cmd.smp_read) begin
            r_alias_q <= alias_mem[i_rand_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && push_small) begin
            sq_mem[r_sh + r_sn[ats_pkg::ENTRY_BITS-1:0]] <= push_data;
        end
        if (push && !push_small) begin
            lq_mem[r_lh + r_ln[ats_pkg::ENTRY_BITS-1:0]] <= push_data;
        end
        if (i_cmd.pr_qread) begin
            r_sq_q <= sq_mem[r_sh];
            r_lq_q <= lq_mem[r_lh];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_mul) begin
            r_prod <= r_sz * r_thr_a;
        end
        if (i_cmd.pr_tread) begin
            r_s <= r_sq_q;
            r_l <= r_lq_q;
        end
        if (i_cmd.pr_calc) begin
            r_tl <= (r_thr_b > gap) ? (r_thr_b - gap) : '0;
        end
        if (i_cmd.smp_read) begin
            r_ridx <= i_rand_index;
            r_frac <= i_rand_fraction;
            r_vld  <= r_valid[i_rand_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hi    <= '0;
            r_cnt   <= '0;
            r_sz    <= '0;
            r_sn    <= '0;
            r_ln    <= '0;
            r_sh    <= '0;
            r_lh    <= '0;
            r_i     <= '0;
            r_ready <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_hi <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_ready <= 1'b0;
                r_ovf   <= ovf;
                if (!ovf) begin
                    r_cnt <= r_cnt + ats_pkg::CNT_BITS'(1);
                end
            end
            if (i_cmd.build_init) begin
                r_sz    <= ovf ? r_cnt : r_cnt + ats_pkg::CNT_BITS'(1);
                r_i     <= '0;
                r_sh    <= '0;
                r_lh    <= '0;
                r_sn    <= '0;
                r_ln    <= '0;
                r_valid <= '0;
            end
            if (i_cmd.sc_write) begin
                r_i <= r_i + ats_pkg::ENTRY_BITS'(1);
            end
            if (i_cmd.pr_tread) begin
                r_sh <= r_sh + ats_pkg::ENTRY_BITS'(1);
                r_lh <= r_lh + ats_pkg::ENTRY_BITS'(1);
            end
            if (i_cmd.pr_write) begin
                r_valid[r_s] <= 1'b1;
            end
            if (push && push_small) begin
                r_sn <= r_sn + ats_pkg::CNT_BITS'(1);
            end else if (i_cmd.pr_tread) begin
                r_sn <= r_sn - ats_pkg::CNT_BITS'(1);
            end
            if (push && !push_small) begin
                r_ln <= r_ln + ats_pkg::CNT_BITS'(1);
            end else if (i_cmd.pr_tread) begin
                r_ln <= r_ln - ats_pkg::CNT_BITS'(1);
            end
            if (i_cmd.finish) begin
                r_cnt   <= '0;
                r_ready <= 1'b1;
            end
        end
    end

    assign took = r_vld && ({{(ats_pkg::THR_BITS-ats_pkg::FRAC_BITS){1'b0}}, r_frac} >= r_thr_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit_ovf | i_cmd.emit_not_built | i_cmd.emit_range
                         | i_cmd.emit_sample | i_cmd.finish;
        end
    end

    always_comb begin
        n_kind    = ats_pkg::KIND_SAMPLE;
        n_outcome = '0;
        n_took    = 1'b0;
        n_status  = ats_pkg::ST_OK;
        priority if (i_cmd.emit_ovf) begin
            n_kind   = ats_pkg::KIND_BUILD;
            n_status = ats_pkg::ST_OVERFLOW;
        end else if (i_cmd.finish) begin
            n_kind   = ats_pkg::KIND_BUILD;
            n_status = r_ovf ? ats_pkg::ST_OVERFLOW : ats_pkg::ST_OK;
        end else if (i_cmd.emit_not_built) begin
            n_status = ats_pkg::ST_NOT_BUILT;
        end else if (i_cmd.emit_range) begin
            n_status = ats_pkg::ST_RANGE;
        end else if (i_cmd.emit_sample) begin
            n_outcome = took ? r_alias_q : r_ridx;
            n_took    = took;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_outcome <= n_outcome;
        r_took    <= n_took;
        r_status  <= n_status;
    end

    assign o_stat.ovf        = ovf;
    assign o_stat.ready      = r_ready;
    assign o_stat.range_err  = (i_rand_index > r_hi);
    assign o_stat.scale_last = ({1'b0, r_i} == (r_sz - ats_pkg::CNT_BITS'(1)));
    assign o_stat.pair_done  = (r_sn == '0) || (r_ln == '0);

    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_outcome      = r_outcome;
    assign o_took_alias   = r_took;
    assign o_status       = r_status;

endmodule

// ----- tb/alias_table_sampler_tb.sv -----
`timescale 1ns / 1ps
module alias_table_sampler_tb;

    typedef struct {
        logic       kind;
        logic [7:0] outcome;
        logic       took_alias;
        logic [1:0] status;
    } t_word;

    class alias_scoreboard;
        logic [ats_pkg::THR_BITS-1:0] thresh [256];
        logic [8:0]                   link [256];
        int unsigned                  loaded;
        bit                           ready;
        int unsigned                  highest;
        t_word                        pending [$];
        int                           errors;

        function void clear();
            foreach (thresh[i]) begin
                thresh[i] = '0;
                link[i] = '0;
            end
            loaded = 0;
            ready = 0;
            highest = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void build();
            int unsigned smallq [$];
            int unsigned largeq [$];
            int unsigned s, l, n;
            logic [63:0] t, gap;
            n = loaded;
            foreach (link[i]) link[i] = '0;
            for (int i = 0; i < n; i++) begin
                t = 64'(n) * 64'(thresh[i]);
                if (t > 64'(ats_pkg::THR_MAX)) t = 64'(ats_pkg::THR_MAX);
                thresh[i] = t[ats_pkg::THR_BITS-1:0];
                if (t < 64'(ats_pkg::ONE_FIX)) smallq.insert(smallq.size(), i);
                else largeq.insert(largeq.size(), i);
            end
            while (smallq.size() != 0 && largeq.size() != 0) begin
                s = smallq.pop_front();
                l = largeq.pop_front();
                link[s] = {1'b1, 8'(l)};
                gap = 64'(ats_pkg::ONE_FIX) - 64'(thresh[s]);
                t = 64'(thresh[l]);
                t = (t > gap) ? t - gap : 0;
                thresh[l] = t[ats_pkg::THR_BITS-1:0];
                if (t < 64'(ats_pkg::ONE_FIX)) smallq.insert(smallq.size(), l);
                else largeq.insert(largeq.size(), l);
            end
            loaded = 0;
            ready = 1;
        endfunction

        function void note_input(logic cmd, logic [16:0] prob, logic last,
                                 logic [7:0] idx, logic [15:0] frac);
            t_word w;
            bit ovf;
            w = '{ats_pkg::KIND_BUILD, 8'd0, 1'b0, ats_pkg::ST_OK};
            if (cmd == ats_pkg::CMD_LOAD) begin
                ovf = 0;
                ready = 0;
                if (loaded >= highest + 1) ovf = 1;
                else begin
                    thresh[loaded] = ats_pkg::THR_BITS'(prob);
                    loaded++;
                end
                if (last && loaded != 0) build();
                if (ovf) begin
                    w.status = ats_pkg::ST_OVERFLOW;
                    pending.insert(pending.size(), w);
                end else if (last) pending.insert(pending.size(), w);
                return;
            end
            w.kind = ats_pkg::KIND_SAMPLE;
            if (!ready) w.status = ats_pkg::ST_NOT_BUILT;
            else if (idx > highest) w.status = ats_pkg::ST_RANGE;
            else if (link[idx][8] && ats_pkg::THR_BITS'(frac) >= thresh[idx]) begin
                w.outcome = link[idx][7:0];
                w.took_alias = 1;
            end else w.outcome = idx;
            pending.insert(pending.size(), w);
        endfunction

        task check_word(logic kind, logic [7:0] oc, logic ta, logic [1:0] st);
            t_word e;
            if (pending.size() == 0) begin
                report_err("word with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind || oc !== e.outcome || ta !== e.took_alias || st !== e.status)
                report_err($sformatf(
                    "got kind %0d outcome %0d alias %0d status %0d, want %0d %0d %0d %0d",
                    kind, oc, ta, st, e.kind, e.outcome, e.took_alias, e.status));
        endtask

        task report_err(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        start;
    logic        busy;
    logic        i_command;
    logic [16:0] i_probability;
    logic        i_last_probability;
    logic [7:0]  i_rand_index;
    logic [15:0] i_rand_fraction;
    logic        o_result_valid;
    logic        o_result_kind;
    logic [7:0]  o_outcome;
    logic        o_took_alias;
    logic [1:0]  o_status;

    alias_scoreboard sb;
    int idle_pct;
    int quiet_cycles;

    alias_table_sampler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .start(start), .busy(busy),
        .i_command(i_command), .i_probability(i_probability),
        .i_last_probability(i_last_probability), .i_rand_index(i_rand_index),
        .i_rand_fraction(i_rand_fraction),
        .o_result_valid(o_result_valid), .o_result_kind(o_result_kind),
        .o_outcome(o_outcome), .o_took_alias(o_took_alias), .o_status(o_status)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_word(o_result_kind, o_outcome, o_took_alias, o_status);
            if (o_result_valid || (start && !busy)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("[alias_table_sampler] ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(logic cmd, logic [16:0] prob, logic last,
                             logic [7:0] idx, logic [15:0] frac);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_command <= cmd;
        i_probability <= prob;
        i_last_probability <= last;
        i_rand_index <= idx;
        i_rand_fraction <= frac;
        do @(posedge i_clk); while (busy);
        sb.note_input(cmd, prob, last, idx, frac);
    endtask

    task automatic write_highest(logic [7:0] v);
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.highest = v;
    endtask

    task automatic rand_sample(int unsigned n);
        send_word(ats_pkg::CMD_SAMPLE, 17'($urandom), 1'($urandom),
                  8'($urandom_range(n + n / 8 + 1 > 255 ? 255 : n + n / 8 + 1)),
                  16'($urandom));
    endtask

    task automatic load_table(int unsigned n, int mode);
        logic [16:0] p;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: p = 17'($urandom_range(65536));
                1: p = 17'($urandom_range(65536 / n + 200));
                default: p = ($urandom_range(3) == 0) ? 17'd65536 : 17'd0;
            endcase
            send_word(ats_pkg::CMD_LOAD, p, i == n - 1, 8'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int unsigned n;
        sb = new();
        sb.clear();
        idle_pct = 0;
        quiet_cycles = 0;
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = 0;
        start = 0;
        i_command = 0;
        i_probability = 0;
        i_last_probability = 0;
        i_rand_index = 0;
        i_rand_fraction = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: not built, highest 0, overflow, extremes
        send_word(ats_pkg::CMD_SAMPLE, 17'd0, 1'b0, 8'd0, 16'd0);
        send_word(ats_pkg::CMD_LOAD, 17'd65536, 1'b0, 8'd255, 16'hffff);
        send_word(ats_pkg::CMD_LOAD, 17'd1, 1'b1, 8'd0, 16'd0);
        send_word(ats_pkg::CMD_SAMPLE, 17'h1ffff, 1'b1, 8'd0, 16'hffff);
        send_word(ats_pkg::CMD_SAMPLE, 17'd0, 1'b0, 8'd1, 16'd0);
        write_highest(8'd3);
        send_word(ats_pkg::CMD_LOAD, 17'd65536, 1'b0, 8'd0, 16'd0);
        send_word(ats_pkg::CMD_LOAD, 17'd0, 1'b0, 8'd0, 16'd0);
        send_word(ats_pkg::CMD_LOAD, 17'h1ffff, 1'b0, 8'd0, 16'd0);
        send_word(ats_pkg::CMD_LOAD, 17'd3, 1'b0, 8'd0, 16'd0);
        send_word(ats_pkg::CMD_LOAD, 17'd9, 1'b1, 8'd0, 16'd0);
        for (int i = 0; i < 5; i++)
            send_word(ats_pkg::CMD_SAMPLE, 17'd0, 1'b0, 8'(i), 16'(i * 16383));
        send_word(ats_pkg::CMD_SAMPLE, 17'd0, 1'b0, 8'd255, 16'hffff);
        // partial load, then sample an entry beyond those loaded
        send_word(ats_pkg::CMD_LOAD, 17'd1000, 1'b1, 8'd0, 16'd0);
        send_word(ats_pkg::CMD_SAMPLE, 17'd0, 1'b0, 8'd2, 16'hffff);
        write_highest(8'd255);
        load_table(256, 0);
        send_word(ats_pkg::CMD_SAMPLE, 17'd0, 1'b0, 8'd255, 16'hffff);

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 78 : 0;
            for (int r = 0; r < 3; r++) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
                write_highest(8'($urandom_range(n - 1 + ($urandom_range(3) == 0), n - 1)));
                if ($urandom_range(5) == 0) begin
                    // noise: a stray load and a sample mid-table
                    send_word(ats_pkg::CMD_LOAD, 17'($urandom), 1'b0, 8'($urandom),
                              16'($urandom));
                    rand_sample(n);
                end
                load_table(n, $urandom_range(2));
                for (int k = 0; k < 12; k++) rand_sample(n);
            end
        end

        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[alias_table_sampler] OK");
        else
            $display("[alias_table_sampler] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ats_pkg.sv
sv/ats_ctrl.sv
sv/ats_datapath.sv
sv/alias_table_sampler.sv
tb/alias_table_sampler_tb.sv
